@@ src/vpid_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_pkg
// Types and constants shared by the velocity-form PID drive.
// ----------------------------------------------------------------------------
package vpid_pkg;

	localparam int ERR_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int CFG_IDX_W = 8;
	localparam int ACC_W   = 32;
	localparam int MAC_W   = 48;
	localparam int QUO_W   = 24;
	localparam int CV_W    = 24;
	localparam int DUTY_W  = 8;
	localparam int COEF_W  = 26;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 8'd3;

	localparam logic [GAIN_W-1:0] PERIOD_RESET = 16'd256;
	localparam logic [DUTY_W-1:0] DRIVE_LIMIT  = 8'd255;

	typedef enum logic [1:0] {
		DIR_BRAKE = 2'd0,
		DIR_CW    = 2'd1,
		DIR_CCW   = 2'd2
	} drv_dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KI,
		ST_DIV,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_SUM,
		ST_OUT
	} vpid_state_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic signed_m;
		logic negate;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage
`default_nettype wire

@@ src/vpid_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_in_if
// Error sample channel.
// ----------------------------------------------------------------------------
interface vpid_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] error_sample;
	modport source (output valid, output error_sample, input ready);
	modport sink (input valid, input error_sample, output ready);
endinterface
`default_nettype wire

@@ src/vpid_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_out_if
// Control result channel.
// ----------------------------------------------------------------------------
interface vpid_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] control_value;
	logic [7:0] duty;
	logic [1:0] drive_dir;
	logic saturated;
	modport source (output valid, output control_value, output duty, output drive_dir,
		output saturated, input ready);
	modport sink (input valid, input control_value, input duty, input drive_dir,
		input saturated, output ready);
endinterface
`default_nettype wire

@@ src/vpid_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface vpid_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/vpid_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_mac
// Bit-serial shift-add multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module vpid_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire vpid_pkg::mac_ctl_t                   ctl,
	input  wire logic signed [vpid_pkg::MAC_W-1:0]    mcand,
	input  wire logic [vpid_pkg::ERR_W-1:0]           mplier,
	output vpid_pkg::unit_stat_t                      stat,
	output logic signed [vpid_pkg::MAC_W-1:0]         acc
);

	localparam logic [3:0] LAST = 4'(vpid_pkg::ERR_W - 1);

	logic signed [vpid_pkg::MAC_W-1:0] mcand_q;
	logic signed [vpid_pkg::MAC_W-1:0] acc_q;
	logic [vpid_pkg::ERR_W-1:0]        mplier_q;
	logic [3:0]                        cnt_q;
	logic                              busy_q;
	logic                              done_q;
	logic                              signed_q;
	logic                              negate_q;
	logic                              sub;

	assign sub = negate_q ^ (signed_q && (cnt_q == LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			signed_q <= 1'b0;
			negate_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				mcand_q  <= mcand;
				mplier_q <= mplier;
				cnt_q    <= '0;
				busy_q   <= 1'b1;
				signed_q <= ctl.signed_m;
				negate_q <= ctl.negate;
				if (ctl.clear) begin
					acc_q <= '0;
				end
			end else if (busy_q) begin
				if (mplier_q[0]) begin
					acc_q <= sub ? acc_q - mcand_q : acc_q + mcand_q;
				end
				mcand_q  <= mcand_q <<< 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q + 4'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign acc       = acc_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("mac done without run");
`endif

endmodule
`default_nettype wire

@@ src/vpid_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vpid_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [vpid_pkg::QUO_W-1:0]        dividend,
	input  wire logic [vpid_pkg::GAIN_W-1:0]       divisor,
	output vpid_pkg::unit_stat_t                   stat,
	output logic [vpid_pkg::QUO_W-1:0]             quotient
);

	localparam logic [4:0] LAST = 5'(vpid_pkg::QUO_W - 1);

	logic [vpid_pkg::GAIN_W-1:0] rem_q;
	logic [vpid_pkg::GAIN_W-1:0] dsr_q;
	logic [vpid_pkg::QUO_W-1:0]  quo_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [vpid_pkg::GAIN_W:0]   rem_sh;
	logic [vpid_pkg::GAIN_W:0]   rem_sub;
	logic                        fits;

	assign rem_sh  = {rem_q, quo_q[vpid_pkg::QUO_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign fits    = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				dsr_q  <= divisor;
				quo_q  <= dividend;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? rem_sub[vpid_pkg::GAIN_W-1:0] : rem_sh[vpid_pkg::GAIN_W-1:0];
				quo_q <= {quo_q[vpid_pkg::QUO_W-2:0], fits};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

@@ src/velocity_pid_hbridge_drive.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_pid_hbridge_drive
// Velocity-form PID with saturating Q24.8 accumulator and H-bridge output.
// ----------------------------------------------------------------------------
// One error word is taken at a time. After acceptance, a restoring divider
// forms Kd/dT beside a bit-serial Ki*dT multiply, then three bit-serial
// multiplies run on one shared accumulator, then the sum/clamp and output
// states load the result word, the output state waiting while the previous
// result is still held.
// Register writes are taken every cycle.
module velocity_pid_hbridge_drive (
	input  wire logic clk,
	input  wire logic arst_n,
	vpid_in_if.sink   din,
	vpid_out_if.source dout,
	vpid_cfg_if.sink  cfg
);

	vpid_pkg::vpid_state_t state_q, state_d;

	logic [15:0] gain_p_q, gain_i_q, gain_d_q, period_q;
	logic signed [15:0] err_q, last_err_q, older_err_q;
	logic signed [31:0] acc_state_q;
	logic sat_q;
	logic [23:0] ki_dt_q;

	logic out_valid_q;
	logic signed [23:0] out_cv_q;
	logic [7:0] out_duty_q;
	vpid_pkg::drv_dir_t out_dir_q;
	logic out_sat_q;

	vpid_pkg::mac_ctl_t mac_ctl;
	vpid_pkg::unit_stat_t mac_st, div_st;
	logic signed [47:0] mac_mcand, mac_acc;
	logic [15:0] mac_mplier;
	logic div_start;
	logic [23:0] kd_dt;
	logic [15:0] dt;
	logic [25:0] c0, c1, c2;
	logic accept, load_out, save_sum, save_ki;

	logic signed [47:0] sum;
	logic signed [31:0] next_acc;
	logic next_sat;
	logic signed [32:0] cv_t;
	logic signed [23:0] cv;
	logic [7:0] duty;
	vpid_pkg::drv_dir_t dir;

	assign dt     = (period_q == 16'd0) ? 16'd1 : period_q;
	assign accept = din.valid && din.ready;
	assign c2 = {2'b00, kd_dt};
	assign c0 = {10'd0, gain_p_q} + {2'b00, ki_dt_q} + c2;
	assign c1 = {10'd0, gain_p_q} + {1'b0, kd_dt, 1'b0};

	vpid_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mac_ctl), .mcand(mac_mcand),
		.mplier(mac_mplier), .stat(mac_st), .acc(mac_acc)
	);

	vpid_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend({gain_d_q, 8'd0}),
		.divisor(dt), .stat(div_st), .quotient(kd_dt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vpid_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mac_ctl    = '0;
		mac_mcand  = '0;
		mac_mplier = '0;
		div_start  = 1'b0;
		save_ki    = 1'b0;
		save_sum   = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			vpid_pkg::ST_IDLE: begin
				if (accept) begin
					mac_ctl    = '{start: 1'b1, clear: 1'b1, signed_m: 1'b0, negate: 1'b0};
					mac_mcand  = {32'd0, gain_i_q};
					mac_mplier = dt;
					div_start  = 1'b1;
					state_d    = vpid_pkg::ST_KI;
				end
			end
			vpid_pkg::ST_KI: begin
				if (mac_st.done) begin
					save_ki = 1'b1;
					state_d = vpid_pkg::ST_DIV;
				end
			end
			vpid_pkg::ST_DIV: begin
				if (div_st.done) begin
					mac_ctl    = '{start: 1'b1, clear: 1'b1, signed_m: 1'b1, negate: 1'b0};
					mac_mcand  = {22'd0, c0};
					mac_mplier = err_q;
					state_d    = vpid_pkg::ST_M0;
				end
			end
			vpid_pkg::ST_M0: begin
				if (mac_st.done) begin
					mac_ctl    = '{start: 1'b1, clear: 1'b0, signed_m: 1'b1, negate: 1'b1};
					mac_mcand  = {22'd0, c1};
					mac_mplier = last_err_q;
					state_d    = vpid_pkg::ST_M1;
				end
			end
			vpid_pkg::ST_M1: begin
				if (mac_st.done) begin
					mac_ctl    = '{start: 1'b1, clear: 1'b0, signed_m: 1'b1, negate: 1'b0};
					mac_mcand  = {22'd0, c2};
					mac_mplier = older_err_q;
					state_d    = vpid_pkg::ST_M2;
				end
			end
			vpid_pkg::ST_M2: begin
				if (mac_st.done) begin
					state_d = vpid_pkg::ST_SUM;
				end
			end
			vpid_pkg::ST_SUM: begin
				save_sum = 1'b1;
				state_d  = vpid_pkg::ST_OUT;
			end
			vpid_pkg::ST_OUT: begin
				if (!out_valid_q || dout.ready) begin
					load_out = 1'b1;
					state_d  = vpid_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vpid_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		sum = {{16{acc_state_q[31]}}, acc_state_q} + mac_acc;
		if (sum > 48'sd2147483647) begin
			next_acc = 32'sh7fffffff;
			next_sat = 1'b1;
		end else if (sum < -48'sd2147483648) begin
			next_acc = 32'sh80000000;
			next_sat = 1'b1;
		end else begin
			next_acc = sum[31:0];
			next_sat = 1'b0;
		end
	end

	always_comb begin
		cv_t = {acc_state_q[31], acc_state_q} + (acc_state_q[31] ? 33'sd255 : 33'sd0);
		cv   = cv_t[31:8];
		if (cv > 24'sd255 || cv < -24'sd255) begin
			duty = vpid_pkg::DRIVE_LIMIT;
		end else if (cv < 0) begin
			duty = 8'(-cv);
		end else begin
			duty = cv[7:0];
		end
		if (cv > 0) begin
			dir = vpid_pkg::DIR_CW;
		end else if (cv < 0) begin
			dir = vpid_pkg::DIR_CCW;
		end else begin
			dir = vpid_pkg::DIR_BRAKE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			period_q    <= vpid_pkg::PERIOD_RESET;
			last_err_q  <= '0;
			older_err_q <= '0;
			acc_state_q <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					vpid_pkg::REG_GAIN_P: gain_p_q <= cfg.data;
					vpid_pkg::REG_GAIN_I: gain_i_q <= cfg.data;
					vpid_pkg::REG_GAIN_D: gain_d_q <= cfg.data;
					vpid_pkg::REG_PERIOD: period_q <= cfg.data;
					default: ;
				endcase
			end
			if (save_sum) begin
				acc_state_q <= next_acc;
				sat_q       <= next_sat;
				older_err_q <= last_err_q;
				last_err_q  <= err_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= din.error_sample;
		end
		if (save_ki) begin
			ki_dt_q <= mac_acc[31:8];
		end
		if (load_out) begin
			out_cv_q   <= cv;
			out_duty_q <= duty;
			out_dir_q  <= dir;
			out_sat_q  <= sat_q;
		end
	end

	assign din.ready          = (state_q == vpid_pkg::ST_IDLE);
	assign cfg.ready          = 1'b1;
	assign dout.valid         = out_valid_q;
	assign dout.control_value = out_cv_q;
	assign dout.duty          = out_duty_q;
	assign dout.drive_dir     = out_dir_q;
	assign dout.saturated     = out_sat_q;

`ifndef SYNTHESIS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == vpid_pkg::ST_KI)
		else $error("accept did not start a step");
	a_div_after_ki: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vpid_pkg::ST_DIV |-> !mac_st.busy && !mac_st.done)
		else $error("mac active while waiting on divider");
	a_brake_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> ((dout.duty == 8'd0) == (dout.drive_dir == vpid_pkg::DIR_BRAKE)))
		else $error("duty and direction disagree");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || dout.ready)
		else $error("result word overwritten");
`endif

endmodule
`default_nettype wire

@@ verif/vpid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_checker
// Watches the register, error and result channels, predicts each result
// word from its own copy of the gains, period and error history, and
// compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module vpid_checker (
	input wire logic clk,
	input wire logic arst_n,
	vpid_in_if.sink  din,
	vpid_out_if.sink dout,
	vpid_cfg_if.sink cfg,
	output int       fail_count,
	output int       pending
);

	typedef struct packed {
		logic signed [23:0] cv;
		logic [7:0]         duty;
		vpid_pkg::drv_dir_t dir;
		logic               sat;
	} ctl_word_t;

	logic [15:0] kp, ki, kd, dt_reg;
	logic signed [15:0] err1, err2;
	logic signed [31:0] acc;
	ctl_word_t ctl_q[$];

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic ctl_word_t pid_update(input logic signed [15:0] e);
		longint dtv, kidt, kddt, c0, c1, c2, nxt, cvl, mag;
		ctl_word_t w;
		dtv  = (dt_reg == 0) ? 1 : longint'(dt_reg);
		kidt = (longint'(ki) * dtv) >>> 8;
		kddt = (longint'(kd) * 256) / dtv;
		c0   = longint'(kp) + kidt + kddt;
		c1   = longint'(kp) + 2 * kddt;
		c2   = kddt;
		nxt  = longint'(acc) + c0 * e - c1 * err1 + c2 * err2;
		w.sat = 1'b0;
		if (nxt > 64'sd2147483647) begin
			nxt = 64'sd2147483647;
			w.sat = 1'b1;
		end else if (nxt < -64'sd2147483648) begin
			nxt = -64'sd2147483648;
			w.sat = 1'b1;
		end
		err2 = err1;
		err1 = e;
		acc  = nxt[31:0];
		cvl  = nxt / 256;
		mag  = cvl < 0 ? -cvl : cvl;
		if (mag > 255) mag = 255;
		w.cv   = cvl[23:0];
		w.duty = mag[7:0];
		w.dir  = cvl > 0 ? vpid_pkg::DIR_CW :
			(cvl < 0 ? vpid_pkg::DIR_CCW : vpid_pkg::DIR_BRAKE);
		return w;
	endfunction

	assign pending = ctl_q.size();

	always @(posedge clk or negedge arst_n) begin
		ctl_word_t w;
		if (!arst_n) begin
			kp <= '0; ki <= '0; kd <= '0; dt_reg <= vpid_pkg::PERIOD_RESET;
			err1 = '0; err2 = '0; acc = '0;
			ctl_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					vpid_pkg::REG_GAIN_P: kp <= cfg.data;
					vpid_pkg::REG_GAIN_I: ki <= cfg.data;
					vpid_pkg::REG_GAIN_D: kd <= cfg.data;
					vpid_pkg::REG_PERIOD: dt_reg <= cfg.data;
					default: ;
				endcase
			end
			if (din.valid && din.ready)
				ctl_q.push_back(pid_update(din.error_sample));
			if (dout.valid && dout.ready) begin
				if (ctl_q.size() == 0) begin
					report("unexpected word", dout.control_value, 0);
				end else begin
					w = ctl_q.pop_front();
					if (dout.control_value !== w.cv)
						report("control_value", dout.control_value, w.cv);
					if (dout.duty !== w.duty) report("duty", dout.duty, w.duty);
					if (dout.drive_dir !== w.dir) report("drive_dir", dout.drive_dir, w.dir);
					if (dout.saturated !== w.sat) report("saturated", dout.saturated, w.sat);
				end
			end
		end
	end

endmodule

@@ verif/velocity_pid_hbridge_drive_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_pid_hbridge_drive_tb
// Drives register settings and error words through the PID drive in
// phases with random idling on both channels; the checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module velocity_pid_hbridge_drive_tb;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   src_idle;
	int   snk_idle;

	vpid_in_if  din ();
	vpid_out_if dout ();
	vpid_cfg_if cfg ();

	velocity_pid_hbridge_drive dut (.clk(clk), .arst_n(arst_n), .din(din), .dout(dout), .cfg(cfg));
	vpid_checker chk (.clk(clk), .arst_n(arst_n), .din(din), .dout(dout), .cfg(cfg),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) dout.ready <= ($urandom_range(99) >= snk_idle);

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic send_error(input logic signed [15:0] e);
		cfg.valid <= 1'b0;
		while ($urandom_range(99) < src_idle) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid <= 1'b1;
		din.error_sample <= e;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
	endtask

	task automatic drain();
		din.valid <= 1'b0;
		cfg.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_gains(input logic [15:0] p, input logic [15:0] i,
		input logic [15:0] d, input logic [15:0] t);
		drain();
		write_reg(vpid_pkg::REG_GAIN_P, p);
		write_reg(vpid_pkg::REG_GAIN_I, i);
		write_reg(vpid_pkg::REG_GAIN_D, d);
		write_reg(vpid_pkg::REG_PERIOD, t);
	endtask

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(3))
			0: return 16'($urandom_range(0, 512));
			1: return 16'($urandom_range(0, 4096));
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] rand_err();
		case ($urandom_range(4))
			0: return 16'sd32767;
			1: return -16'sd32768;
			2: return 16'($signed($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int ph;
		arst_n = 1'b0;
		din.valid = 1'b0; din.error_sample = '0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		dout.ready = 1'b0;
		src_idle = 6; snk_idle = 74;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset gains: all zero
		send_error(16'sd1000);
		set_gains(16'd256, 16'd0, 16'd0, 16'd256);
		send_error(16'sd100); send_error(-16'sd100); send_error(16'sd0);
		send_error(16'sd1); send_error(-16'sd1);
		set_gains(16'd0, 16'd1, 16'd0, 16'd256);
		send_error(16'sd200); send_error(-16'sd200); send_error(16'sd0);
		set_gains(16'd0, 16'd0, 16'd300, 16'd0);
		send_error(16'sd5); send_error(-16'sd5); send_error(16'sd3);
		drain();
		write_reg(8'd7, 16'h1234);
		set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (int k = 0; k < 4; k++) send_error(16'sd32767);
		for (int k = 0; k < 5; k++) send_error(-16'sd32768);
		for (ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 6 : (ph == 1) ? 74 : 0;
			snk_idle = (ph == 0) ? 74 : (ph == 1) ? 6 : 0;
			for (int s = 0; s < 7; s++) begin
				set_gains(rand_gain(), rand_gain(), rand_gain(),
					($urandom_range(9) == 0) ? 16'($urandom_range(0, 1)) : rand_gain());
				for (int k = 0; k < 40; k++) send_error(rand_err());
			end
		end
		drain();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
